@@ sv/f32c_pkg.sv @@
// ----------------------------------------------------------------------------
// f32c_pkg
// Shared types and constants for the Fletcher-32 checksum block.
// ----------------------------------------------------------------------------
package f32c_pkg;

   localparam int WORD_W      = 16;
   localparam int SUM_W       = 32;
   localparam int FOLD_W      = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One classified word on its way from the front to the back
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              fold;
   } entry_type;

endpackage

@@ sv/f32c_front.sv @@
// ----------------------------------------------------------------------------
// f32c_front
// Accepts input words, tracks the position in the current block and marks
// each word that closes a block or a message.
// ----------------------------------------------------------------------------
module f32c_front #(
   parameter int BLOCK_WORDS = 360
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [15:0]              req_word,
   input  logic                     req_last,
   output logic                     req_stall,
   input  logic                     queue_full,
   output logic                     push_valid,
   output f32c_pkg::entry_type      push_entry
);
   import f32c_pkg::*;

   localparam int POS_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             accept;
   logic             fold;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign fold      = req_last || (pos_ff == POS_W'(BLOCK_WORDS - 1));

   assign push_valid       = accept;
   assign push_entry.word  = req_word;
   assign push_entry.last  = req_last;
   assign push_entry.fold  = fold;

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = fold ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

@@ sv/f32c_queue.sv @@
// ----------------------------------------------------------------------------
// f32c_queue
// Short flip-flop queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module f32c_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  f32c_pkg::entry_type push_entry,
   output logic                full,
   output logic                pop_valid,
   output f32c_pkg::entry_type pop_entry,
   input  logic                pop
);
   import f32c_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/f32c_back.sv @@
// ----------------------------------------------------------------------------
// f32c_back
// Runs the two sums, folds at block and message ends, and drives the result
// through a pending stage (final fold) and the output register.
// ----------------------------------------------------------------------------
module f32c_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  f32c_pkg::entry_type pop_entry,
   output logic                pop,
   output logic                rsp_valid,
   output logic [31:0]         rsp_checksum,
   input  logic                rsp_stall
);
   import f32c_pkg::*;

   function automatic logic [FOLD_W-1:0] fold16(input logic [SUM_W-1:0] v);
      return {1'b0, v[15:0]} + {1'b0, v[31:16]};
   endfunction

   logic [SUM_W-1:0]  first_ff, first_in;
   logic [SUM_W-1:0]  second_ff, second_in;
   logic [SUM_W-1:0]  first_add, second_add;
   logic [SUM_W-1:0]  first_fold, second_fold;
   logic              pend_valid_ff, pend_valid_in;
   logic [FOLD_W-1:0] pend_first_ff, pend_second_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_checksum_ff;
   logic              rsp_load;
   logic              pend_free;
   logic [15:0]       fin_first, fin_second;

   assign rsp_load  = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pend_free = !pend_valid_ff || rsp_load;
   assign pop       = pop_valid && (!pop_entry.last || pend_free);

   always_comb begin
      first_add  = first_ff + SUM_W'(pop_entry.word);
      second_add = second_ff + first_ff + SUM_W'(pop_entry.word);
      first_fold  = pop_entry.fold ? SUM_W'(fold16(first_add)) : first_add;
      second_fold = pop_entry.fold ? SUM_W'(fold16(second_add)) : second_add;

      first_in  = first_ff;
      second_in = second_ff;
      if (pop) begin
         // drop the sums once the message closes
         first_in  = pop_entry.last ? '0 : first_fold;
         second_in = pop_entry.last ? '0 : second_fold;
      end

      pend_valid_in = pend_valid_ff;
      if (pop && pop_entry.last) begin
         pend_valid_in = 1'b1;
      end else if (rsp_load) begin
         pend_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      fin_first  = pend_first_ff[15:0] + 16'(pend_first_ff[16]);
      fin_second = pend_second_ff[15:0] + 16'(pend_second_ff[16]);
   end

   always_ff @(posedge clock) begin
      if (pop && pop_entry.last) begin
         pend_first_ff  <= first_fold[FOLD_W-1:0];
         pend_second_ff <= second_fold[FOLD_W-1:0];
      end
      if (rsp_load) begin
         rsp_checksum_ff <= {fin_second, fin_first};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff      <= '0;
         second_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_ff      <= first_in;
         second_ff     <= second_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_checksum_ff;

endmodule

@@ sv/fletcher32_checksum_top.sv @@
// ----------------------------------------------------------------------------
// fletcher32_checksum_top
// Fletcher-32 checksum over a stream of 16-bit words, deferred-fold form.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  req_word[15:0], req_last
//   rsp      out        rsp_valid/rsp_stall  rsp_checksum[31:0]
//
// One word is taken every cycle while req_stall is low; the accumulator loop
// adds each popped word into the registered sums. After the last word is
// accepted, the result passes the queue write, pending stage and output register.
// Synchronous reset clears the sums, block position, queue and valid flags.
// A stalled result holds; the four-entry queue and pending stage keep input
// flowing until they fill, then req_stall rises.
// ----------------------------------------------------------------------------
module fletcher32_checksum_top #(
   parameter int BLOCK_WORDS = 360
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [15:0] req_word,
   input  logic        req_last,
   output logic        req_stall,
   output logic        rsp_valid,
   output logic [31:0] rsp_checksum,
   input  logic        rsp_stall
);
   import f32c_pkg::*;

   logic      queue_full;
   logic      push_valid;
   entry_type push_entry;
   logic      pop_valid;
   entry_type pop_entry;
   logic      pop;

   f32c_front #(.BLOCK_WORDS(BLOCK_WORDS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_last   (req_last),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   f32c_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   f32c_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_checksum (rsp_checksum),
      .rsp_stall    (rsp_stall)
   );

endmodule

@@ sv/f32c_checker.sv @@
// ----------------------------------------------------------------------------
// f32c_checker
// Port-level checks for the Fletcher-32 checksum block.
// ----------------------------------------------------------------------------
module f32c_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic [31:0] rsp_checksum,
   input logic        rsp_stall
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_checksum))
      else $error("rsp transaction changed while stalled");

   // a stalled request transaction stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("req transaction dropped while stalled");

   // reset empties the queue and the output register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // a result never appears straight out of reset
   a_rsp_latency: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2))
      else $error("result appeared too soon after reset");

endmodule

bind fletcher32_checksum_top f32c_checker u_f32c_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_checksum (rsp_checksum),
   .rsp_stall    (rsp_stall)
);

@@ verif/fletcher32_checksum_top_tb.sv @@
// ----------------------------------------------------------------------------
// fletcher32_checksum_top_tb
// Self-checking bench for the Fletcher-32 checksum block. A queue of words is
// driven with random gaps. Every accepted word updates a local copy of the
// running sums, and each message end queues the expected checksum. A monitor
// with random stalls compares every result with the oldest expected checksum.
// ----------------------------------------------------------------------------
module fletcher32_checksum_top_tb;
   import f32c_pkg::*;

   localparam int BLOCK_WORDS    = 360;
   localparam int ITEM_TARGET    = 1950;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;

   typedef enum int {
      CONTENT_RANDOM,
      CONTENT_ONES,
      CONTENT_ZEROS,
      CONTENT_EDGES
   } content_kind_type;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic              last;
      int                gap;
      bit                drain;   // wait until every checksum is back
      bit                hold;    // start the long receiver hold
   } word_item_type;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic [WORD_W-1:0] req_word     = '0;
   logic              req_last     = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [SUM_W-1:0]  rsp_checksum;
   logic              rsp_stall    = 1'b0;

   word_item_type    pending_q[$];
   logic [SUM_W-1:0] checksum_q[$];

   // running sums of the message in flight
   logic [SUM_W-1:0] sum_a   = '0;
   logic [SUM_W-1:0] sum_b   = '0;
   logic [8:0]       blk_pos = '0;

   int error_count  = 0;
   int queued_items = 0;
   int gap_left     = -1;
   int stall_left   = 0;
   int hold_left    = 0;
   int idle_cycles  = 0;
   bit tx_calm      = 1'b0;
   bit rx_calm      = 1'b0;
   bit next_drain   = 1'b0;
   bit next_hold    = 1'b0;
   bit rx_hold_req  = 1'b0;

   fletcher32_checksum_top #(.BLOCK_WORDS(BLOCK_WORDS)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_word     (req_word),
      .req_last     (req_last),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_checksum (rsp_checksum),
      .rsp_stall    (rsp_stall)
   );

   always #2 clock = ~clock;

   function automatic logic [SUM_W-1:0] fold_halves(input logic [SUM_W-1:0] v);
      return {16'h0000, v[15:0]} + {16'h0000, v[31:16]};
   endfunction

   // Advance the running sums by one accepted word; queue a checksum at the end.
   task automatic absorb_word(input logic [WORD_W-1:0] w, input logic lst);
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
      logic [8:0]       p;
      a = sum_a + {16'h0000, w};
      b = sum_b + a;
      p = blk_pos + 9'd1;
      if (p >= BLOCK_WORDS || lst) begin
         a = fold_halves(a);
         b = fold_halves(b);
         p = '0;
      end
      if (lst) begin
         a = fold_halves(a);
         b = fold_halves(b);
         checksum_q.push_back({b[15:0], a[15:0]});
         a = '0;
         b = '0;
         p = '0;
      end
      sum_a   = a;
      sum_b   = b;
      blk_pos = p;
   endtask

   task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                  input logic [SUM_W-1:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   function automatic logic [WORD_W-1:0] pick_word(input content_kind_type kind);
      case (kind)
         CONTENT_ONES:  return 16'hFFFF;
         CONTENT_ZEROS: return 16'h0000;
         CONTENT_EDGES: begin
            case ($urandom_range(0, 4))
               0:       return 16'h0000;
               1:       return 16'h0001;
               2:       return 16'h8000;
               3:       return 16'hFFFE;
               default: return 16'hFFFF;
            endcase
         end
         default:       return WORD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic add_word(input logic [WORD_W-1:0] w, input logic lst);
      word_item_type it;
      it.word  = w;
      it.last  = lst;
      it.gap   = tx_calm ? 0 : $urandom_range(0, 14);
      it.drain = next_drain;
      it.hold  = next_hold;
      next_drain = 1'b0;
      next_hold  = 1'b0;
      pending_q.push_back(it);
      queued_items++;
   endtask

   task automatic add_message(input int len, input content_kind_type kind);
      for (int i = 0; i < len; i++)
         add_word(pick_word(kind), i == len - 1);
   endtask

   // Driver: present the next word once its gap has elapsed; hold while stalled.
   always @(posedge clock) begin
      word_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_word  <= '0;
         req_last  <= 1'b0;
         gap_left = -1;
      end else begin
         if (req_valid && !req_stall)
            absorb_word(req_word, req_last);
         if (!req_valid || !req_stall) begin
            if (gap_left < 0 && pending_q.size() != 0)
               gap_left = pending_q[0].gap;
            if (gap_left == 0 && !(pending_q[0].drain && checksum_q.size() != 0)) begin
               nxt = pending_q.pop_front();
               if (nxt.hold)
                  rx_hold_req = 1'b1;
               req_valid <= 1'b1;
               req_word  <= nxt.word;
               req_last  <= nxt.last;
               gap_left = -1;
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end
         end
      end
   end

   // Monitor: check each result transaction, then draw the next stall.
   always @(posedge clock) begin
      logic [SUM_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (checksum_q.size() == 0) begin
               report_mismatch("unexpected checksum", rsp_checksum, '0);
            end else begin
               want = checksum_q.pop_front();
               if (rsp_checksum !== want)
                  report_mismatch("checksum", rsp_checksum, want);
            end
            stall_left = rx_calm ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 31) == 0)
               rx_calm = !rx_calm;
         end
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      content_kind_type kind;
      int               len;

      // single-word messages at the field extremes, then one two-word message
      add_word(16'h0000, 1'b1);
      add_word(16'hFFFF, 1'b1);
      add_word(16'h8000, 1'b1);
      add_word(16'h0001, 1'b1);
      add_word(16'h5555, 1'b0);
      add_word(16'hAAAA, 1'b1);
      // all-ones messages leave 0xFFFF after folding
      add_message(4, CONTENT_ONES);
      add_message(10, CONTENT_ONES);
      add_message(3, CONTENT_ZEROS);

      // last word on a block boundary, then one past it
      next_drain = 1'b1;
      add_message(BLOCK_WORDS, CONTENT_ONES);
      add_message(BLOCK_WORDS + 1, CONTENT_RANDOM);

      // long receiver hold with back-to-back short messages behind it
      tx_calm    = 1'b1;
      next_drain = 1'b1;
      next_hold  = 1'b1;
      for (int i = 0; i < 40; i++)
         add_message($urandom_range(1, 2), CONTENT_RANDOM);
      tx_calm    = 1'b0;
      next_drain = 1'b1;

      while (queued_items < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0)
            tx_calm = !tx_calm;
         if ($urandom_range(0, 49) == 0)
            next_drain = 1'b1;
         case ($urandom_range(0, 9))
            0:       kind = CONTENT_ONES;
            1:       kind = CONTENT_ZEROS;
            2, 3:    kind = CONTENT_EDGES;
            default: kind = CONTENT_RANDOM;
         endcase
         if ($urandom_range(0, 39) == 0) begin
            case ($urandom_range(0, 2))
               0:       len = BLOCK_WORDS;
               1:       len = 2 * BLOCK_WORDS;
               default: len = $urandom_range(BLOCK_WORDS - 5, 2 * BLOCK_WORDS + 5);
            endcase
         end else begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 24);
         end
         // trim the last message to the item budget
         if (len > ITEM_TARGET - queued_items)
            len = ITEM_TARGET - queued_items;
         add_message(len, kind);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || checksum_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
